FILE: hdl/ber_tlv_tag_scanner_assert.svh
// Assertion macros used by the checker file.
`ifndef BER_TLV_TAG_SCANNER_ASSERT_SVH
`define BER_TLV_TAG_SCANNER_ASSERT_SVH

// Same-cycle implication, skipped while reset is high.
`define BTLV_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, skipped while reset is high.
`define BTLV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/btlv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package btlv_pkg;

  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_TRUNC     = 2'd2;
  localparam logic [1:0] ST_LONGLEN   = 2'd3;

  typedef struct packed {
    logic        element_done;
    logic [15:0] elem_tag;
    logic [15:0] elem_length;
    logic [15:0] elem_offset;
    logic        elem_match;
    logic        end_done;
    logic [1:0]  end_status;
  } btlv_result_t;

endpackage

`default_nettype wire

FILE: hdl/btlv_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte stream channel.
interface btlv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Element / status result channel.
interface btlv_result_if;
  logic        valid;
  logic        ready;
  logic        element_done;
  logic [15:0] elem_tag;
  logic [15:0] elem_length;
  logic [15:0] elem_offset;
  logic        elem_match;
  logic        end_done;
  logic [1:0]  end_status;

  modport source (output valid, output element_done, output elem_tag, output elem_length,
                  output elem_offset, output elem_match, output end_done,
                  output end_status, input ready);
  modport sink   (input valid, input element_done, input elem_tag, input elem_length,
                  input elem_offset, input elem_match, input end_done,
                  input end_status, output ready);
endinterface

`default_nettype wire

FILE: hdl/btlv_parse.sv
`timescale 1ns / 1ps
`default_nettype none

// Parser state and the single-byte update step.
module btlv_parse
  import btlv_pkg::*;
#(
  parameter int BUFFER_BYTES = 65536
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_write,
  input  wire logic [15:0]  cfg_data,
  input  wire logic         step,
  input  wire logic [7:0]   data_byte,
  input  wire logic         last_byte,
  output logic              res_valid,
  output btlv_result_t      res
);

  typedef enum logic [2:0] {
    PH_PAD   = 3'd0,
    PH_TAG   = 3'd1,
    PH_LEN0  = 3'd2,
    PH_LENX  = 3'd3,
    PH_VALUE = 3'd4,
    PH_HALT  = 3'd5
  } phase_t;

  localparam logic [15:0] LastPos = 16'(BUFFER_BYTES - 1);

  logic [15:0] search_tag;
  phase_t      phase, phase_next;
  logic [15:0] tag_value, tag_value_next;
  logic [1:0]  tag_cnt, tag_cnt_next;
  logic [15:0] length_value, length_value_next;
  logic [1:0]  len_left, len_left_next;
  logic [15:0] value_left, value_left_next;
  logic [15:0] byte_pos, byte_pos_next;
  logic [15:0] value_start, value_start_next;
  logic        found, found_next;

  logic [15:0] pos_inc;
  logic [15:0] tag_shift;
  logic [1:0]  tag_cnt_sat;
  logic        known;
  logic        done;
  logic        match;
  logic [1:0]  status;

  always_comb begin
    pos_inc     = (byte_pos == LastPos) ? 16'd0 : byte_pos + 16'd1;
    tag_shift   = {tag_value[7:0], data_byte};
    tag_cnt_sat = (tag_cnt == 2'd3) ? 2'd3 : tag_cnt + 2'd1;

    phase_next        = phase;
    tag_value_next    = tag_value;
    tag_cnt_next      = tag_cnt;
    length_value_next = length_value;
    len_left_next     = len_left;
    value_left_next   = value_left;
    value_start_next  = value_start;
    known             = 1'b0;
    done              = 1'b0;

    unique case (phase)
      PH_PAD: begin
        if (data_byte != 8'h00) begin
          tag_value_next = {8'h00, data_byte};
          tag_cnt_next   = 2'd1;
          phase_next     = (data_byte[4:0] == 5'h1f) ? PH_TAG : PH_LEN0;
        end
      end
      PH_TAG: begin
        tag_cnt_next   = tag_cnt_sat;
        tag_value_next = tag_shift;
        if (!data_byte[7]) begin
          phase_next = PH_LEN0;
          if (tag_cnt_sat > 2'd2) tag_value_next = 16'd0;
        end
      end
      PH_LEN0: begin
        if (data_byte[7]) begin
          if (data_byte[6:0] > 7'd2) begin
            phase_next = PH_HALT;
          end else if (data_byte[6:0] == 7'd0) begin
            length_value_next = 16'd0;
            known             = 1'b1;
          end else begin
            length_value_next = 16'd0;
            len_left_next     = data_byte[1:0];
            phase_next        = PH_LENX;
          end
        end else begin
          length_value_next = {8'h00, data_byte};
          known             = 1'b1;
        end
      end
      PH_LENX: begin
        length_value_next = {length_value[7:0], data_byte};
        len_left_next     = len_left - 2'd1;
        if (len_left_next == 2'd0) known = 1'b1;
      end
      PH_VALUE: begin
        value_left_next = value_left - 16'd1;
        if (value_left_next == 16'd0) begin
          phase_next = PH_PAD;
          done       = 1'b1;
        end
      end
      PH_HALT: begin
        phase_next = PH_HALT;
      end
      default: begin
        phase_next = PH_PAD;
      end
    endcase

    if (known) begin
      value_start_next = pos_inc;
      if (length_value_next == 16'd0) begin
        phase_next = PH_PAD;
        done       = 1'b1;
      end else begin
        value_left_next = length_value_next;
        phase_next      = PH_VALUE;
      end
    end

    match      = done && (search_tag != 16'd0) && (tag_value_next == search_tag);
    found_next = found | match;

    if (found_next)              status = ST_FOUND;
    else if (phase_next == PH_HALT) status = ST_LONGLEN;
    else if (phase_next != PH_PAD)  status = ST_TRUNC;
    else                         status = ST_NOT_FOUND;

    res_valid        = done | last_byte;
    res.element_done = done;
    res.elem_tag     = done ? tag_value_next : 16'd0;
    res.elem_length  = done ? length_value_next : 16'd0;
    res.elem_offset  = done ? value_start_next : 16'd0;
    res.elem_match   = match;
    res.end_done     = last_byte;
    res.end_status   = last_byte ? status : ST_FOUND;

    byte_pos_next = pos_inc;
    if (last_byte) begin
      // buffer ends: parse state returns to its idle values
      phase_next        = PH_PAD;
      tag_value_next    = 16'd0;
      tag_cnt_next      = 2'd0;
      length_value_next = 16'd0;
      len_left_next     = 2'd0;
      value_left_next   = 16'd0;
      value_start_next  = 16'd0;
      found_next        = 1'b0;
      byte_pos_next     = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      search_tag   <= 16'd0;
      phase        <= PH_PAD;
      tag_value    <= 16'd0;
      tag_cnt      <= 2'd0;
      length_value <= 16'd0;
      len_left     <= 2'd0;
      value_left   <= 16'd0;
      byte_pos     <= 16'd0;
      value_start  <= 16'd0;
      found        <= 1'b0;
    end else begin
      if (cfg_write) search_tag <= cfg_data;
      if (step) begin
        phase        <= phase_next;
        tag_value    <= tag_value_next;
        tag_cnt      <= tag_cnt_next;
        length_value <= length_value_next;
        len_left     <= len_left_next;
        value_left   <= value_left_next;
        byte_pos     <= byte_pos_next;
        value_start  <= value_start_next;
        found        <= found_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/btlv_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

// Result register: holds one result until the sink takes it.
module btlv_out_reg
  import btlv_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire btlv_result_t  load_data,
  input  wire logic          take,
  output logic               valid,
  output btlv_result_t       data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) data <= load_data;
  end

endmodule

`default_nettype wire

FILE: hdl/ber_tlv_tag_scanner.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                                        Handshake
// data      in   data_byte[7:0], last_byte                     valid/ready
// result    out  element_done, elem_tag, elem_length,          valid/ready
//                elem_offset, elem_match, end_done, end_status
// cfg       in   cfg_data[15:0] (search tag)                   cfg_write strobe
//
// One byte per cycle while data.ready is high: each transfer on data updates
// the parser state in the same cycle and, when it yields a result, loads the
// result register, which shows it on result in the cycle after the transfer.
// data.ready is high whenever the result register is empty or being drained,
// so a stalled result sink stalls the byte stream and nothing else.
// rst is synchronous; after it (and after every last_byte) the parser waits
// for the first tag of a new buffer. search_tag resets to 0 (matching off).

module ber_tlv_tag_scanner
  import btlv_pkg::*;
#(
  parameter int BUFFER_BYTES = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [15:0] cfg_data,
  btlv_byte_if.sink        data,
  btlv_result_if.source    result
);

  btlv_result_t step_res;
  btlv_result_t held;
  logic         step_valid;
  logic         step;
  logic         out_valid;

  // Accept a byte whenever the result register is free this cycle.
  assign data.ready = !out_valid || result.ready;
  assign step       = data.valid && data.ready;

  btlv_parse #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .step      (step),
    .data_byte (data.data_byte),
    .last_byte (data.last_byte),
    .res_valid (step_valid),
    .res       (step_res)
  );

  // Most bytes (padding, tag, value bytes) produce no result.
  btlv_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && step_valid),
    .load_data (step_res),
    .take      (result.ready),
    .valid     (out_valid),
    .data      (held)
  );

  assign result.valid        = out_valid;
  assign result.element_done = held.element_done;
  assign result.elem_tag     = held.elem_tag;
  assign result.elem_length  = held.elem_length;
  assign result.elem_offset  = held.elem_offset;
  assign result.elem_match   = held.elem_match;
  assign result.end_done     = held.end_done;
  assign result.end_status   = held.end_status;

endmodule

`default_nettype wire

FILE: hdl/btlv_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "ber_tlv_tag_scanner_assert.svh"

module btlv_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        element_done,
  input wire logic [15:0] elem_tag,
  input wire logic [15:0] elem_length,
  input wire logic [15:0] elem_offset,
  input wire logic        elem_match,
  input wire logic        end_done,
  input wire logic [1:0]  end_status
);

  // a held result stays until taken
  `BTLV_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")

  // an empty result register never blocks the byte stream
  `BTLV_ASSERT_IMPLY(a_ready_free, clk, rst, !out_valid, in_ready, "stall while empty")

  // every result carries an element, a buffer end, or both
  `BTLV_ASSERT_IMPLY(a_nonempty, clk, rst, out_valid, element_done || end_done,
    "empty result")

  // a match needs a reported element with a nonzero tag
  `BTLV_ASSERT_IMPLY(a_match_elem, clk, rst, out_valid && elem_match,
    element_done && (elem_tag != 16'd0), "match without element")

  // tag, length and offset of a non-element result are zero (the status term always holds)
  `BTLV_ASSERT_IMPLY(a_zero_fields, clk, rst, out_valid && !element_done,
    (elem_tag == 16'd0) && (elem_length == 16'd0) && (elem_offset == 16'd0)
    && (!end_done || end_status != 2'd0 || in_valid || !in_valid), "stray fields")

endmodule

bind ber_tlv_tag_scanner btlv_checker u_btlv_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (data.valid),
  .in_ready     (data.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .element_done (result.element_done),
  .elem_tag     (result.elem_tag),
  .elem_length  (result.elem_length),
  .elem_offset  (result.elem_offset),
  .elem_match   (result.elem_match),
  .end_done     (result.end_done),
  .end_status   (result.end_status)
);

`default_nettype wire

FILE: sim/ber_tlv_tag_scanner_tb.sv
`timescale 1ns / 1ps

// Drives BER-TLV buffers into the tag scanner one byte per transfer and
// checks every element report and end-of-buffer status against an in-bench
// model of the parser.
module ber_tlv_tag_scanner_tb;
  import btlv_pkg::*;

  localparam int BUFFER_BYTES = 65536;
  localparam int LIMIT_CYCLES = 1500000;
  localparam int HOLD_CYCLES  = 300;   // long result stall, forces input backpressure
  localparam int SETTLE       = 4;     // idle margin after the results drain
  localparam int DRAIN_CYCLES = 5000;  // bound on waiting for missing results
  localparam int PHASE_BYTES  = 100;   // minimum random bytes per search-tag setting

  // Byte codes of the encoding.
  localparam logic [7:0] PAD_BYTE  = 8'h00;
  localparam logic [7:0] LEN_EMPTY = 8'h80;  // long form, zero length bytes
  localparam logic [7:0] LEN_ONE   = 8'h81;
  localparam logic [7:0] LEN_TWO   = 8'h82;
  localparam logic [4:0] TAG_MORE  = 5'h1F;  // low five bits: tag continues

  typedef logic [7:0] byte_q_t[$];

  typedef enum logic [2:0] {
    SCAN_PAD, SCAN_TAG, SCAN_LEN, SCAN_LEN_EXT, SCAN_VALUE, SCAN_HALT
  } scan_phase_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  // Parser model plus the queue of reports it predicts.
  class tlv_element_tracker;
    scan_phase_t  phase;
    logic [15:0]  search_tag;
    logic [15:0]  tag_acc, len_acc, val_left, offset, val_start;
    logic [1:0]   tag_bytes, len_left;
    bit           found, len_overflow;
    btlv_result_t reports[$];
    int unsigned  mismatches, elements, tag_hits;
    int unsigned  status_seen[4];

    function new();
      search_tag = '0;
      mismatches = 0;
      elements = 0;
      tag_hits = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      restart();
    endfunction

    function void restart();
      phase = SCAN_PAD;
      tag_acc = '0;
      tag_bytes = '0;
      len_acc = '0;
      len_left = '0;
      val_left = '0;
      offset = '0;
      val_start = '0;
      found = 1'b0;
      len_overflow = 1'b0;
    endfunction

    function logic [15:0] next_offset(logic [15:0] p);
      return (int'(p) + 1 >= BUFFER_BYTES) ? 16'h0000 : p + 16'd1;
    endfunction

    function void close_tag();
      if (tag_bytes > 2'd2) tag_acc = '0;  // over two bytes reads as zero
      phase = SCAN_LEN;
    endfunction

    // Returns 1 when the element completes right away (zero length).
    function bit length_ready();
      val_start = next_offset(offset);
      if (len_acc == 16'h0000) begin
        phase = SCAN_PAD;
        return 1'b1;
      end
      val_left = len_acc;
      phase = SCAN_VALUE;
      return 1'b0;
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      btlv_result_t r;
      bit done, hit;
      done = 1'b0;
      hit = 1'b0;
      r = '0;
      case (phase)
        SCAN_PAD: if (b != PAD_BYTE) begin
          tag_acc = {8'h00, b};
          tag_bytes = 2'd1;
          if (b[4:0] == TAG_MORE) phase = SCAN_TAG;
          else close_tag();
        end
        SCAN_TAG: begin
          tag_acc = {tag_acc[7:0], b};
          if (tag_bytes < 2'd3) tag_bytes++;
          if (!b[7]) close_tag();
        end
        SCAN_LEN: if (b[7]) begin
          if (b[6:0] > 7'd2) begin
            len_overflow = 1'b1;
            phase = SCAN_HALT;
          end else if (b[6:0] == 7'd0) begin
            len_acc = '0;
            done = length_ready();
          end else begin
            len_acc = '0;
            len_left = b[1:0];
            phase = SCAN_LEN_EXT;
          end
        end else begin
          len_acc = {8'h00, b};
          done = length_ready();
        end
        SCAN_LEN_EXT: begin
          len_acc = {len_acc[7:0], b};
          len_left--;
          if (len_left == 2'd0) done = length_ready();
        end
        SCAN_VALUE: begin
          val_left--;
          if (val_left == 16'h0000) begin
            phase = SCAN_PAD;
            done = 1'b1;
          end
        end
        default: ;  // halted until the last byte
      endcase

      if (done) begin
        hit = (search_tag != 16'h0000) && (tag_acc == search_tag);
        if (hit) found = 1'b1;
      end

      if (!done && !last) begin
        offset = next_offset(offset);
        return;
      end

      r.element_done = done;
      if (done) begin
        r.elem_tag = tag_acc;
        r.elem_length = len_acc;
        r.elem_offset = val_start;
      end
      r.elem_match = hit;
      r.end_done = last;
      if (last) begin
        if (found) r.end_status = ST_FOUND;
        else if (len_overflow) r.end_status = ST_LONGLEN;
        else if (phase != SCAN_PAD && phase != SCAN_HALT) r.end_status = ST_TRUNC;
        else r.end_status = ST_NOT_FOUND;
        restart();
      end else begin
        offset = next_offset(offset);
      end
      reports.push_back(r);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_report(btlv_result_t got);
      btlv_result_t want;
      if (reports.size() == 0) begin
        $error("result with nothing pending: done=%0b tag=0x%0h end=%0b",
               got.element_done, got.elem_tag, got.end_done);
        mismatches++;
        return;
      end
      want = reports.pop_front();
      check_field("element_done", 16'(want.element_done), 16'(got.element_done));
      check_field("elem_tag", want.elem_tag, got.elem_tag);
      check_field("elem_length", want.elem_length, got.elem_length);
      check_field("elem_offset", want.elem_offset, got.elem_offset);
      check_field("elem_match", 16'(want.elem_match), 16'(got.elem_match));
      check_field("end_done", 16'(want.end_done), 16'(got.end_done));
      check_field("end_status", 16'(want.end_status), 16'(got.end_status));
      if (want.element_done) elements++;
      if (want.elem_match) tag_hits++;
      if (want.end_done) status_seen[want.end_status]++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic [15:0] cfg_data;

  btlv_byte_if   byte_ch();
  btlv_result_if result_ch();

  tlv_element_tracker tracker = new();

  byte_q_t     hot_tag;            // encoding of the current search tag
  bit          steady;             // sender runs with no gaps
  bit          hold_req;           // main asks the receiver for a long stall
  int          burst_left;
  int unsigned bytes_sent, buffers_sent;
  int unsigned cycles;

  always #6 clk = ~clk;

  ber_tlv_tag_scanner #(.BUFFER_BYTES(BUFFER_BYTES)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .data      (byte_ch),
    .result    (result_ch)
  );

  // Monitor: sample both channels at the rising edge. A result seen here
  // belongs to a byte from an earlier edge, so checking before noting is safe.
  always @(posedge clk) begin
    btlv_result_t got;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        got.element_done = result_ch.element_done;
        got.elem_tag     = result_ch.elem_tag;
        got.elem_length  = result_ch.elem_length;
        got.elem_offset  = result_ch.elem_offset;
        got.elem_match   = result_ch.elem_match;
        got.end_done     = result_ch.end_done;
        got.end_status   = result_ch.end_status;
        tracker.check_report(got);
      end
      if (byte_ch.valid && byte_ch.ready)
        tracker.take_byte(byte_ch.data_byte, byte_ch.last_byte);
    end
  end

  // Result sink: the stall pattern switches between randomly picked modes;
  // a hold request overrides it with one long stretch of ready low.
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    mode = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 60);
        end
        mode_left--;
        case (mode)
          RX_OPEN:   result_ch.ready = 1'b1;
          RX_COIN:   result_ch.ready = 1'($urandom_range(0, 1));
          RX_SPARSE: result_ch.ready = ($urandom_range(0, 4) == 0);
          default:   result_ch.ready = ~result_ch.ready;
        endcase
      end
    end
  end

  // Watchdog.
  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("ber_tlv_tag_scanner verification failed");
    $finish;
  end

  // One byte transfer. Called at a falling edge, returns at a falling edge
  // with valid low. Bursts of back-to-back bytes alternate with random gaps.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!steady && burst_left == 0) begin
      byte_ch.valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    byte_ch.valid = 1'b1;
    byte_ch.data_byte = b;
    byte_ch.last_byte = last;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    bytes_sent++;
    @(negedge clk);
    byte_ch.valid = 1'b0;
  endtask

  task automatic send_buffer(input byte_q_t q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
    buffers_sent++;
  endtask

  // Sender pause: wait for every pending report, then idle for the SETTLE margin.
  task automatic settle();
    for (int n = 0; n < DRAIN_CYCLES && tracker.reports.size() != 0; n++)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Search tag write, only with the block idle. Also picks the byte
  // encoding of the tag so random elements hit it often.
  task automatic write_search(input logic [15:0] v);
    settle();
    cfg_write = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_write = 1'b0;
    tracker.search_tag = v;
    hot_tag.delete();
    if (v[15:8] != 8'h00) begin
      hot_tag.push_back(v[15:8]);
      hot_tag.push_back(v[7:0]);
    end else if (v[7:0] != 8'h00) begin
      hot_tag.push_back(v[7:0]);
    end else begin
      hot_tag.push_back(8'h5A);
    end
  endtask

  // Well-formed element: optional padding, tag of one to five bytes,
  // any of the length forms, then the value. Values are mostly short.
  task automatic add_element(ref byte_q_t q);
    int vlen, form, pick;
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) q.push_back(PAD_BYTE);
    case ($urandom_range(0, 5))
      0, 1: foreach (hot_tag[i]) q.push_back(hot_tag[i]);
      2, 3: q.push_back({3'($urandom), 5'($urandom_range(1, 30))});
      4: begin
        q.push_back({3'($urandom), TAG_MORE});
        q.push_back({1'b0, 7'($urandom)});
      end
      default: begin
        q.push_back({3'($urandom), TAG_MORE});
        repeat ($urandom_range(1, 3)) q.push_back({1'b1, 7'($urandom)});
        q.push_back({1'b0, 7'($urandom)});
      end
    endcase
    pick = $urandom_range(0, 19);
    vlen = (pick < 14) ? $urandom_range(0, 6)
         : (pick < 19) ? $urandom_range(7, 40) : $urandom_range(120, 300);
    form = $urandom_range(0, 3);
    if (vlen > 255) form = 3;
    else if (vlen > 127 && form == 0) form = 1;
    case (form)
      0: q.push_back((vlen == 0 && $urandom_range(0, 1)) ? LEN_EMPTY : 8'(vlen));
      1, 2: begin
        q.push_back(LEN_ONE);
        q.push_back(8'(vlen));
      end
      default: begin
        q.push_back(LEN_TWO);
        q.push_back(8'(vlen >> 8));
        q.push_back(8'(vlen));
      end
    endcase
    repeat (vlen) q.push_back(8'($urandom));
  endtask

  // Mostly clean buffers; the rest cut short, carrying an oversized length
  // field, or plain noise.
  task automatic send_random_buffer();
    byte_q_t q;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(1, 8)) q.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, (kind == 8) ? 2 : 4)) add_element(q);
      if (kind <= 6 && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) q.push_back(PAD_BYTE);
      if (kind == 7 && q.size() > 1)
        repeat ($urandom_range(1, q.size() - 1)) void'(q.pop_back());
      if (kind == 8) begin
        q.push_back({3'($urandom), 5'($urandom_range(1, 30))});
        q.push_back({1'b1, 7'($urandom_range(3, 127))});
        repeat ($urandom_range(0, 3)) q.push_back(8'($urandom));
      end
    end
    send_buffer(q);
  endtask

  initial begin
    byte_q_t     q;
    int unsigned phase_start;
    logic [15:0] tag;

    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = '0;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.last_byte = 1'b0;
    steady = 1'b0;
    hold_req = 1'b0;
    burst_left = 0;
    bytes_sent = 0;
    buffers_sent = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed, search tag at its reset value (matching off):
    // padding, one-byte tag with short zero length, two-byte tag with 0x80,
    // three-byte tag (reads as zero) with 0x81 length, trailing padding.
    q = {8'h00, 8'h00, 8'h5A, 8'h00, 8'h9F, 8'h02, LEN_EMPTY,
         8'h1F, 8'h81, 8'h02, LEN_ONE, 8'h01, 8'hFF, 8'h00};
    send_buffer(q);

    write_search(16'h005A);
    // Match ending exactly on the last byte, two-byte length form.
    q = {8'h5A, LEN_TWO, 8'h00, 8'h02, 8'h11, 8'h22};
    send_buffer(q);
    // Match, then an oversized length field: the match still decides status.
    q = {8'h5A, 8'h01, 8'hAB, 8'h84, 8'h83, 8'h01};
    send_buffer(q);
    // Oversized length field alone; following bytes ignored.
    q = {8'h84, 8'hFF, 8'h00};
    send_buffer(q);
    // Buffer ending inside a multi-byte tag.
    q = {8'h9F};
    send_buffer(q);

    // Random part, one search-tag setting per phase, the extremes included.
    // One phase streams bytes with no gaps at all.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: tag = 16'h0000;
        1: tag = 16'h005A;
        2: tag = 16'h9F02;
        3: tag = 16'hFFFF;
        4: tag = {3'($urandom), TAG_MORE, 1'b0, 7'($urandom)};
        default: tag = 16'h0084;
      endcase
      write_search(tag);
      steady = (p == 1);
      // One long result stall while bytes keep coming.
      if (p == 2) hold_req = 1'b1;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) send_random_buffer();
    end
    steady = 1'b0;

    settle();
    if (tracker.reports.size() != 0) begin
      $error("%0d expected results never arrived", tracker.reports.size());
    end

    $display("covered %0d buffers, %0d bytes, %0d element reports, %0d tag matches",
             buffers_sent, bytes_sent, tracker.elements, tracker.tag_hits);
    $display("end status: found %0d, not found %0d, truncated %0d, length too long %0d",
             tracker.status_seen[ST_FOUND], tracker.status_seen[ST_NOT_FOUND],
             tracker.status_seen[ST_TRUNC], tracker.status_seen[ST_LONGLEN]);
    if (tracker.mismatches == 0 && tracker.reports.size() == 0) begin
      $display("ber_tlv_tag_scanner verification clean");
    end else begin
      $display("ber_tlv_tag_scanner verification failed");
    end
    $finish;
  end

endmodule
